// File: rtl/mcbq_pkg.sv
// Shared widths, operation and status codes and sequencer states for the multi-channel bounded queue.
package mcbq_pkg;

   localparam int REQ_CHANNEL_W = 6;
   localparam int REQ_CAPACITY_W = 9;
   localparam int VALUE_W = 64;

   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_SEND    = 3'd1,
      OP_RECEIVE = 3'd2,
      OP_COUNT   = 3'd3,
      OP_CLOSE   = 3'd4,
      OP_DESTROY = 3'd5,
      OP_QUERY   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      STS_OK     = 3'd0,
      STS_BAD    = 3'd1,
      STS_FULL   = 3'd2,
      STS_CLOSED = 3'd3,
      STS_EMPTY  = 3'd4,
      STS_NOFREE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

endpackage

// File: rtl/mcbq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mcbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/multi_channel_bounded_queue.sv
// Top level of the multi-channel bounded queue: request sequencer and channel memories.
//
//  port group   direction  handshake          payload
//  req_*        in         start & !busy      operation, channel, value, capacity
//  rsp_*        out        rsp_valid strobe   status, data
//
// Each request passes IDLE and EXEC: the accept edge reads the channel's state word,
// the next edge writes it back and reads or writes the value memory, and the result
// is strobed in the cycle after that, while busy is already low again.
// Both accesses of one request finish before the next request's first read, so no
// forwarding is needed. Reset clears the allocation bits and the sequencer only;
// no clearing pass is run. The receiver cannot stall: each result is shown once.
module multi_channel_bounded_queue #(
   parameter int NUM_CHANNELS  = 64,
   parameter int CHANNEL_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_operation,
   input  logic [mcbq_pkg::REQ_CHANNEL_W-1:0]   req_channel,
   input  logic signed [mcbq_pkg::VALUE_W-1:0]  req_value,
   input  logic [mcbq_pkg::REQ_CAPACITY_W-1:0]  req_capacity,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_status,
   output logic signed [mcbq_pkg::VALUE_W-1:0]  rsp_data
);

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PTR_W  = $clog2(CHANNEL_DEPTH);
   localparam int CNT_W  = $clog2(CHANNEL_DEPTH + 1);
   localparam int VDEPTH = NUM_CHANNELS * CHANNEL_DEPTH;
   localparam int VA_W   = $clog2(VDEPTH);
   localparam int CHX_W  = 9;

   typedef struct packed {
      logic             closed;
      logic [CNT_W-1:0] cap;
      logic [CNT_W-1:0] fill;
      logic [PTR_W-1:0] rd_ptr;
      logic [PTR_W-1:0] wr_ptr;
   } chan_state_type;

   localparam int STATE_W = $bits(chan_state_type);

   mcbq_pkg::fsm_type fsm_ff, fsm_in;
   logic [NUM_CHANNELS-1:0] in_use_ff, in_use_in;

   logic [2:0]                      op_ff;
   logic [CHX_W-1:0]                chan_ff;
   logic [mcbq_pkg::VALUE_W-1:0]    value_ff;
   logic [mcbq_pkg::REQ_CAPACITY_W-1:0] capacity_ff;

   logic [CH_W-1:0] free_idx_ff, free_idx_in;
   logic            any_free_ff, any_free_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_status_ff, rsp_status_in;
   logic [mcbq_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         from_ram_ff, from_ram_in;

   logic           accept;
   logic [CHX_W-1:0] req_chan_wide;
   logic [CH_W-1:0]  chan_idx;
   logic           chan_ok;

   chan_state_type st_rd, st_wr;
   logic [STATE_W-1:0] st_rd_raw;
   logic               st_we;
   logic [CH_W-1:0]    st_wr_addr;

   logic                         v_we, v_re;
   logic [PTR_W-1:0]             v_ptr;
   logic [VA_W-1:0]              v_addr;
   logic [mcbq_pkg::VALUE_W-1:0] v_rdata;

   logic [CNT_W-1:0] cap_new;
   logic [CNT_W-1:0] wr_next, rd_next;

   assign accept        = start && (fsm_ff == mcbq_pkg::FSM_IDLE);
   assign busy          = (fsm_ff == mcbq_pkg::FSM_EXEC);
   assign req_chan_wide = CHX_W'(req_channel);
   assign chan_idx      = chan_ff[CH_W-1:0];
   assign chan_ok       = (chan_ff < CHX_W'(NUM_CHANNELS)) && in_use_ff[chan_idx];
   assign st_rd         = chan_state_type'(st_rd_raw);

   // lowest free channel, refreshed every cycle from the allocation bits
   always_comb begin
      free_idx_in = '0;
      any_free_in = 1'b0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_idx_in = CH_W'(i);
            any_free_in = 1'b1;
         end
      end
   end

   always_comb begin
      if ((capacity_ff == '0) || (32'(capacity_ff) > 32'(CHANNEL_DEPTH))) begin
         cap_new = CNT_W'(CHANNEL_DEPTH);
      end else begin
         cap_new = CNT_W'(capacity_ff);
      end
      // wrap by compare against the channel's capacity
      wr_next = CNT_W'(st_rd.wr_ptr) + CNT_W'(1);
      if (wr_next >= st_rd.cap) begin
         wr_next = '0;
      end
      rd_next = CNT_W'(st_rd.rd_ptr) + CNT_W'(1);
      if (rd_next >= st_rd.cap) begin
         rd_next = '0;
      end
   end

   always_comb begin
      fsm_in        = fsm_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      from_ram_in   = from_ram_ff;
      st_we         = 1'b0;
      st_wr_addr    = chan_idx;
      st_wr         = st_rd;
      v_we          = 1'b0;
      v_re          = 1'b0;
      v_ptr         = st_rd.wr_ptr;

      unique case (fsm_ff)
         mcbq_pkg::FSM_IDLE: begin
            if (accept) begin
               fsm_in = mcbq_pkg::FSM_EXEC;
            end
         end
         mcbq_pkg::FSM_EXEC: begin
            fsm_in        = mcbq_pkg::FSM_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = mcbq_pkg::STS_OK;
            rsp_data_in   = '0;
            from_ram_in   = 1'b0;
            if (op_ff == mcbq_pkg::OP_CREATE) begin
               if (any_free_ff) begin
                  in_use_in[free_idx_ff] = 1'b1;
                  st_we       = 1'b1;
                  st_wr_addr  = free_idx_ff;
                  st_wr       = '0;
                  st_wr.cap   = cap_new;
                  rsp_data_in = mcbq_pkg::VALUE_W'(free_idx_ff);
               end else begin
                  rsp_status_in = mcbq_pkg::STS_NOFREE;
               end
            end else if (!chan_ok) begin
               rsp_status_in = mcbq_pkg::STS_BAD;
               if (op_ff == mcbq_pkg::OP_QUERY) begin
                  rsp_data_in = mcbq_pkg::VALUE_W'(1);
               end
            end else begin
               case (op_ff)
                  mcbq_pkg::OP_SEND: begin
                     if (st_rd.closed) begin
                        rsp_status_in = mcbq_pkg::STS_CLOSED;
                     end else if (st_rd.fill >= st_rd.cap) begin
                        rsp_status_in = mcbq_pkg::STS_FULL;
                     end else begin
                        v_we         = 1'b1;
                        v_ptr        = st_rd.wr_ptr;
                        st_we        = 1'b1;
                        st_wr.wr_ptr = wr_next[PTR_W-1:0];
                        st_wr.fill   = st_rd.fill + CNT_W'(1);
                     end
                  end
                  mcbq_pkg::OP_RECEIVE: begin
                     if (st_rd.fill == '0) begin
                        rsp_status_in = mcbq_pkg::STS_EMPTY;
                     end else begin
                        v_re         = 1'b1;
                        v_ptr        = st_rd.rd_ptr;
                        from_ram_in  = 1'b1;
                        st_we        = 1'b1;
                        st_wr.rd_ptr = rd_next[PTR_W-1:0];
                        st_wr.fill   = st_rd.fill - CNT_W'(1);
                     end
                  end
                  mcbq_pkg::OP_COUNT: begin
                     rsp_data_in = mcbq_pkg::VALUE_W'(st_rd.fill);
                  end
                  mcbq_pkg::OP_CLOSE: begin
                     st_we        = 1'b1;
                     st_wr.closed = 1'b1;
                  end
                  mcbq_pkg::OP_DESTROY: begin
                     // drop the channel; its state word is rewritten when a create claims it again
                     in_use_in[chan_idx] = 1'b0;
                  end
                  mcbq_pkg::OP_QUERY: begin
                     rsp_data_in = mcbq_pkg::VALUE_W'(st_rd.closed);
                  end
                  default: begin
                     rsp_status_in = mcbq_pkg::STS_BAD;
                  end
               endcase
            end
         end
         default: begin
            fsm_in = mcbq_pkg::FSM_IDLE;
         end
      endcase
   end

   assign v_addr = VA_W'(chan_idx * CHANNEL_DEPTH + 32'(v_ptr));

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= mcbq_pkg::FSM_IDLE;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_operation;
         chan_ff     <= req_chan_wide;
         value_ff    <= req_value;
         capacity_ff <= req_capacity;
         free_idx_ff <= free_idx_in;
         any_free_ff <= any_free_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      from_ram_ff   <= from_ram_in;
   end

   mcbq_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wr_addr),
      .wr_data (STATE_W'(st_wr)),
      .rd_en   (accept),
      .rd_addr (req_chan_wide[CH_W-1:0]),
      .rd_data (st_rd_raw)
   );

   mcbq_ram #(
      .WIDTH (mcbq_pkg::VALUE_W),
      .DEPTH (VDEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_addr),
      .wr_data (value_ff),
      .rd_en   (v_re),
      .rd_addr (v_addr),
      .rd_data (v_rdata)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = from_ram_ff ? $signed(v_rdata) : $signed(rsp_data_ff);

endmodule

// File: sim/mcbq_checker.sv
// Checker for the multi-channel bounded queue: predicts each reply and compares it.
module mcbq_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic [2:0]                              req_operation,
   input  logic [mcbq_pkg::REQ_CHANNEL_W-1:0]      req_channel,
   input  logic signed [mcbq_pkg::VALUE_W-1:0]     req_value,
   input  logic [mcbq_pkg::REQ_CAPACITY_W-1:0]     req_capacity,
   input  logic                                    rsp_valid,
   input  logic [2:0]                              rsp_status,
   input  logic signed [mcbq_pkg::VALUE_W-1:0]     rsp_data,
   output int                                      mismatches,
   output int                                      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS = 64;
   localparam int DEPTH    = 256;

   typedef struct packed {
      logic [2:0]                   status;
      logic [mcbq_pkg::VALUE_W-1:0] data;
   } reply_type;

   reply_type expected_replies[$];
   reply_type oldest;

   logic                         allocated [CHANNELS];
   logic                         is_closed [CHANNELS];
   logic [8:0]                   chan_cap  [CHANNELS];
   logic [8:0]                   fill      [CHANNELS];
   logic [7:0]                   rd_ptr    [CHANNELS];
   logic [7:0]                   wr_ptr    [CHANNELS];
   logic [mcbq_pkg::VALUE_W-1:0] values    [CHANNELS][DEPTH];

   // Apply one request to the channel pool and return the reply it should give.
   function automatic reply_type apply_channel_op(logic [2:0] op, logic [5:0] ch,
                                                  logic [mcbq_pkg::VALUE_W-1:0] val,
                                                  logic [8:0] cap_req);
      reply_type  r;
      logic [8:0] size;
      logic [8:0] nxt;
      int         slot;
      r.status = mcbq_pkg::STS_OK;
      r.data = '0;
      slot = -1;
      if (op == mcbq_pkg::OP_CREATE) begin
         size = (cap_req == 9'd0 || cap_req > 9'(DEPTH)) ? 9'(DEPTH) : cap_req;
         r.status = mcbq_pkg::STS_NOFREE;
         for (int i = 0; i < CHANNELS; i++) begin
            if (!allocated[i] && slot < 0) slot = i;
         end
         if (slot >= 0) begin
            allocated[slot] = 1'b1;
            is_closed[slot] = 1'b0;
            chan_cap[slot]  = size;
            fill[slot]      = '0;
            rd_ptr[slot]    = '0;
            wr_ptr[slot]    = '0;
            r.status = mcbq_pkg::STS_OK;
            r.data = mcbq_pkg::VALUE_W'(slot);
         end
      end else if (!allocated[ch] || op > mcbq_pkg::OP_QUERY) begin
         // a dead handle reads as closed; the spare code never does
         r.status = mcbq_pkg::STS_BAD;
         if (op == mcbq_pkg::OP_QUERY) r.data = mcbq_pkg::VALUE_W'(1);
      end else begin
         case (op)
            mcbq_pkg::OP_SEND: begin
               if (is_closed[ch]) begin
                  r.status = mcbq_pkg::STS_CLOSED;
               end else if (fill[ch] >= chan_cap[ch]) begin
                  r.status = mcbq_pkg::STS_FULL;
               end else begin
                  values[ch][wr_ptr[ch]] = val;
                  nxt = {1'b0, wr_ptr[ch]} + 9'd1;
                  wr_ptr[ch] = (nxt >= chan_cap[ch]) ? 8'd0 : nxt[7:0];
                  fill[ch] = fill[ch] + 9'd1;
               end
            end
            mcbq_pkg::OP_RECEIVE: begin
               if (fill[ch] == 9'd0) begin
                  r.status = mcbq_pkg::STS_EMPTY;
               end else begin
                  r.data = values[ch][rd_ptr[ch]];
                  nxt = {1'b0, rd_ptr[ch]} + 9'd1;
                  rd_ptr[ch] = (nxt >= chan_cap[ch]) ? 8'd0 : nxt[7:0];
                  fill[ch] = fill[ch] - 9'd1;
               end
            end
            mcbq_pkg::OP_COUNT: r.data = mcbq_pkg::VALUE_W'(fill[ch]);
            mcbq_pkg::OP_CLOSE: is_closed[ch] = 1'b1;
            mcbq_pkg::OP_DESTROY: begin
               allocated[ch] = 1'b0;
               is_closed[ch] = 1'b0;
               chan_cap[ch]  = '0;
               fill[ch]      = '0;
               rd_ptr[ch]    = '0;
               wr_ptr[ch]    = '0;
            end
            default: r.data = mcbq_pkg::VALUE_W'(is_closed[ch]);
         endcase
      end
      return r;
   endfunction

   function automatic void report_failure(string what, reply_type want);
      if (mismatches < 10)
         $display("%0t: %s: expected status %0d data %h, got status %0d data %h",
                  $realtime, what, want.status, want.data, rsp_status, rsp_data);
      mismatches++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_replies.delete();
         for (int i = 0; i < CHANNELS; i++) begin
            allocated[i] = 1'b0;
            is_closed[i] = 1'b0;
            chan_cap[i]  = '0;
            fill[i]      = '0;
            rd_ptr[i]    = '0;
            wr_ptr[i]    = '0;
         end
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               report_failure("reply with no request pending", '0);
            end else begin
               oldest = expected_replies.pop_front();
               if (rsp_status !== oldest.status || rsp_data !== oldest.data)
                  report_failure("reply mismatch", oldest);
            end
         end
         if (start && !busy)
            expected_replies.push_back(apply_channel_op(req_operation, req_channel,
                                                        req_value, req_capacity));
         outstanding <= expected_replies.size();
      end
   end

endmodule

// File: sim/tb.sv
// Testbench top for the multi-channel bounded queue: clock, reset, request stimulus, verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE       = 3'd7;
   localparam int         NUM_HANDLES    = 64;
   localparam int         TARGET_ITEMS   = 1050;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam logic [mcbq_pkg::VALUE_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [mcbq_pkg::VALUE_W-1:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    start = 1'b0;
   logic [2:0]                              req_operation = '0;
   logic [mcbq_pkg::REQ_CHANNEL_W-1:0]      req_channel = '0;
   logic signed [mcbq_pkg::VALUE_W-1:0]     req_value = '0;
   logic [mcbq_pkg::REQ_CAPACITY_W-1:0]     req_capacity = '0;
   logic                                    busy;
   logic                                    rsp_valid;
   logic [2:0]                              rsp_status;
   logic signed [mcbq_pkg::VALUE_W-1:0]     rsp_data;

   int                mismatches;
   int                outstanding;
   int                requests_sent = 0;
   int                burst_left = 0;
   int                idle_cycles = 0;
   logic [NUM_HANDLES-1:0] live = '0;

   multi_channel_bounded_queue u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_channel   (req_channel),
      .req_value     (req_value),
      .req_capacity  (req_capacity),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data)
   );

   mcbq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_channel   (req_channel),
      .req_value     (req_value),
      .req_capacity  (req_capacity),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .outstanding   (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stop the run if neither a request nor a reply moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [mcbq_pkg::VALUE_W-1:0] rand_value();
      return {$urandom, $urandom};
   endfunction

   function automatic int lowest_free();
      for (int i = 0; i < NUM_HANDLES; i++) begin
         if (!live[i]) return i;
      end
      return NUM_HANDLES;
   endfunction

   function automatic int pick_live();
      int n;
      int k;
      n = $countones(live);
      if (n == 0) return -1;
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < NUM_HANDLES; i++) begin
         if (live[i]) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   // Mostly small rings, now and then any legal size, full depth or an out-of-range request.
   function automatic logic [8:0] random_capacity();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 9'($urandom_range(1, 8));
      if (r < 78) return 9'd0;
      if (r < 84) return 9'($urandom_range(257, 511));
      return 9'($urandom_range(1, 256));
   endfunction

   // Present one request, hold it until accepted, then maybe pause.
   task automatic issue(input logic [2:0] op, input int ch,
                        input logic [mcbq_pkg::VALUE_W-1:0] val, input logic [8:0] cap);
      int slot;
      slot = lowest_free();
      req_operation <= op;
      req_channel   <= 6'(ch);
      req_value     <= val;
      req_capacity  <= cap;
      start         <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      requests_sent++;
      if (op == mcbq_pkg::OP_CREATE && slot < NUM_HANDLES) live[slot] = 1'b1;
      if (op == mcbq_pkg::OP_DESTROY) live[ch] = 1'b0;
      if (burst_left == 0) begin
         start       <= 1'b0;
         req_value   <= rand_value();
         req_channel <= 6'($urandom_range(0, 63));
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic channel_traffic();
      int ch;
      int r;
      logic [2:0] op;
      ch = pick_live();
      if (ch < 0 || $urandom_range(0, 7) == 0) begin
         issue(mcbq_pkg::OP_CREATE, $urandom_range(0, 63), rand_value(), random_capacity());
         ch = pick_live();
      end
      if (ch >= 0) begin
         repeat ($urandom_range(2, 14)) begin
            r = $urandom_range(0, 99);
            op = (r < 55) ? mcbq_pkg::OP_SEND
               : (r < 88) ? mcbq_pkg::OP_RECEIVE
               : (r < 93) ? mcbq_pkg::OP_COUNT
               : (r < 97) ? mcbq_pkg::OP_QUERY : mcbq_pkg::OP_CLOSE;
            issue(op, ch, rand_value(), 9'($urandom_range(0, 511)));
         end
         if ($urandom_range(0, 4) == 0) issue(mcbq_pkg::OP_DESTROY, ch, rand_value(), '0);
      end
   endtask

   task automatic exhaust_pool();
      while (lowest_free() < NUM_HANDLES)
         issue(mcbq_pkg::OP_CREATE, $urandom_range(0, 63), rand_value(), random_capacity());
      issue(mcbq_pkg::OP_CREATE, $urandom_range(0, 63), rand_value(), random_capacity());
      for (int i = 0; i < NUM_HANDLES; i++) begin
         if (live[i] && $urandom_range(0, 1) == 0)
            issue(mcbq_pkg::OP_DESTROY, i, rand_value(), '0);
      end
   endtask

   initial begin
      int ch;
      int r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: capacity one, closed and full at once, drain after close
      issue(mcbq_pkg::OP_CREATE,  0, '0, 9'd1);
      issue(mcbq_pkg::OP_SEND,    0, MOST_NEG, '0);
      issue(mcbq_pkg::OP_SEND,    0, MOST_POS, '0);
      issue(mcbq_pkg::OP_COUNT,   0, '0, '0);
      issue(mcbq_pkg::OP_RECEIVE, 0, '0, '0);
      issue(mcbq_pkg::OP_RECEIVE, 0, '0, '0);
      issue(mcbq_pkg::OP_SEND,    0, MOST_POS, '0);
      issue(mcbq_pkg::OP_CLOSE,   0, '0, '0);
      issue(mcbq_pkg::OP_SEND,    0, '1, '0);
      issue(mcbq_pkg::OP_CREATE,  0, '0, 9'd511);
      issue(mcbq_pkg::OP_CREATE,  0, '0, 9'd257);
      issue(mcbq_pkg::OP_SEND,    1, '1, '0);
      issue(mcbq_pkg::OP_CLOSE,   1, '0, '0);
      issue(mcbq_pkg::OP_CLOSE,   1, '0, '0);
      issue(mcbq_pkg::OP_QUERY,   1, '0, '0);
      issue(mcbq_pkg::OP_RECEIVE, 1, '0, '0);
      issue(mcbq_pkg::OP_RECEIVE, 1, '0, '0);
      issue(mcbq_pkg::OP_DESTROY, 1, '0, '0);
      issue(mcbq_pkg::OP_SEND,    1, MOST_POS, '0);
      issue(mcbq_pkg::OP_QUERY,   1, '0, '0);
      issue(OP_SPARE,             2, '0, '0);
      issue(mcbq_pkg::OP_QUERY,   2, '0, '0);
      issue(mcbq_pkg::OP_DESTROY, 0, '0, '0);
      issue(mcbq_pkg::OP_COUNT,   0, '0, '0);
      issue(mcbq_pkg::OP_QUERY,  63, '0, '0);

      // full-depth ring: fill past full, wrap both pointers, drain past empty
      ch = lowest_free();
      issue(mcbq_pkg::OP_CREATE, 0, '0, 9'd0);
      repeat (257) issue(mcbq_pkg::OP_SEND, ch, rand_value(), '0);
      repeat (20) issue(mcbq_pkg::OP_RECEIVE, ch, '0, '0);
      repeat (20) issue(mcbq_pkg::OP_SEND, ch, rand_value(), '0);
      issue(mcbq_pkg::OP_COUNT, ch, '0, '0);
      repeat (257) issue(mcbq_pkg::OP_RECEIVE, ch, '0, '0);
      issue(mcbq_pkg::OP_DESTROY, ch, '0, '0);

      while (requests_sent < TARGET_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            channel_traffic();
         end else if (r < 78) begin
            exhaust_pool();
         end else if (r < 84) begin
            ch = pick_live();
            if (ch >= 0) issue(mcbq_pkg::OP_DESTROY, ch, rand_value(), '0);
         end else begin
            issue(3'($urandom_range(0, 7)), $urandom_range(0, 63), rand_value(),
                  9'($urandom_range(0, 511)));
         end
      end

      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
